[rtl/pid2_pkg.sv]
package pid2_pkg;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned ERR_W    = POS_W + 1;
  localparam int unsigned DRIVE_W  = 16;
  localparam int unsigned PGAIN_W  = 16;
  localparam int unsigned IGAIN_W  = 24;
  localparam int unsigned DGAIN_W  = 24;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned AVG_DEPTH_DEF = 3;

  localparam logic signed [PGAIN_W-1:0] PROP_GAIN_RST  = 16'sd10240;
  localparam logic signed [IGAIN_W-1:0] INTEG_GAIN_RST = '0;
  localparam logic signed [DGAIN_W-1:0] DERIV_GAIN_RST = -24'sd211200;
  localparam logic [LIMIT_W-1:0]        INT_LIMIT_RST  = 15'd512;
  localparam logic [LIMIT_W-1:0]        OUT_LIMIT_RST  = 15'd10240;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN          = 3'd0,
    CFG_INTEG_GAIN_DT      = 3'd1,
    CFG_DERIV_GAIN_OVER_DT = 3'd2,
    CFG_INT_LIMIT          = 3'd3,
    CFG_OUT_LIMIT          = 3'd4
  } pid2_cfg_reg_e;

  // per-stage load strobes shared by both lanes
  typedef struct packed {
    logic take;
    logic s2;
    logic s3;
    logic s4;
  } pid2_adv_t;

endpackage

[rtl/pid2_in_if.sv]
interface pid2_in_if;
  import pid2_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] target_x;
  logic [POS_W-1:0] target_y;

  modport source (output valid, pos_x, pos_y, target_x, target_y, input ready);
  modport sink   (input valid, pos_x, pos_y, target_x, target_y, output ready);
endinterface

[rtl/pid2_out_if.sv]
interface pid2_out_if;
  import pid2_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_x;
  logic signed [DRIVE_W-1:0] drive_y;

  modport source (output valid, drive_x, drive_y, input ready);
  modport sink   (input valid, drive_x, drive_y, output ready);
endinterface

[rtl/pid2_lane.sv]
module pid2_lane #(
  parameter int unsigned AvgDepth = pid2_pkg::AVG_DEPTH_DEF,
  parameter int unsigned SlotW    = 2
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  pid2_pkg::pid2_adv_t                       adv_i,
  input  logic [pid2_pkg::POS_W-1:0]                pos_i,
  input  logic [pid2_pkg::POS_W-1:0]                target_i,
  input  logic [SlotW-1:0]                          slot_i,
  input  logic signed [pid2_pkg::PGAIN_W-1:0]       prop_gain_i,
  input  logic signed [pid2_pkg::IGAIN_W-1:0]       integ_gain_i,
  input  logic signed [pid2_pkg::DGAIN_W-1:0]       deriv_gain_i,
  input  logic [pid2_pkg::LIMIT_W-1:0]              int_limit_i,
  input  logic [pid2_pkg::LIMIT_W-1:0]              out_limit_i,
  output logic signed [pid2_pkg::DRIVE_W-1:0]       drive_o
);
  import pid2_pkg::*;

  localparam int unsigned SumW  = ERR_W + $clog2(AvgDepth);
  localparam int unsigned PPW   = PGAIN_W + ERR_W;
  localparam int unsigned IPW   = IGAIN_W + ERR_W;
  localparam int unsigned DPW   = SumW + DGAIN_W;
  localparam int unsigned DW    = DPW - 16;
  localparam int unsigned IW    = IPW - 24;
  localparam int unsigned PW    = PPW - 16;
  localparam int unsigned TW    = DW + 3;
  // floor(u / AvgDepth) = (u * RecipM) >> Shift, exact for u < 2^DW
  localparam int unsigned Shift = DW + $clog2(AvgDepth);
  localparam longint unsigned Pow = 64'd1 << Shift;
  localparam logic [DW:0] RecipM = (DW+1)'(Pow / AvgDepth + 64'd1);

  // stage 0 state: measurement history
  logic [POS_W-1:0]         last_pos_q;
  logic signed [ERR_W-1:0]  ring_q [AvgDepth];
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic signed [ERR_W-1:0]  err, diff;
  logic signed [PPW-1:0]    pprod;
  logic signed [IPW-1:0]    iprod;

  // stage 1
  logic signed [PPW-1:0]    s1_pprod_q;
  logic signed [IPW-1:0]    s1_iprod_q;
  logic signed [SumW-1:0]   s1_sum_q;

  // integrator
  logic signed [DRIVE_W-1:0] integ_q, integ_d;
  logic signed [DRIVE_W+1:0] int_sum, int_lim;
  logic signed [IW-1:0]      i_inc;
  logic signed [DPW-1:0]     dprod;

  // stage 2
  logic signed [PW-1:0]      s2_p_q;
  logic signed [DRIVE_W-1:0] s2_integ_q;
  logic signed [DPW-1:0]     s2_dprod_q;
  logic signed [DW-1:0]      x2;
  logic signed [DW:0]        x2_ext;
  logic [DW-1:0]             u_d;

  // stage 3
  logic signed [PW-1:0]      s3_p_q;
  logic signed [DRIVE_W-1:0] s3_integ_q;
  logic [DW-1:0]             s3_u_q;
  logic                      s3_neg_q;
  logic [2*DW:0]             mprod;

  // stage 4
  logic signed [PW-1:0]      s4_p_q;
  logic signed [DRIVE_W-1:0] s4_integ_q;
  logic [DW-1:0]             s4_q_q;
  logic                      s4_neg_q;
  logic signed [DW:0]        dq, d_val;
  logic signed [TW-1:0]      total, olim, clamped;

  assign err   = $signed(ERR_W'(target_i)) - $signed(ERR_W'(pos_i));
  assign diff  = $signed(ERR_W'(pos_i)) - $signed(ERR_W'(last_pos_q));
  assign sum_d = sum_q - SumW'(ring_q[slot_i]) + SumW'(diff);
  assign pprod = prop_gain_i * err;
  assign iprod = integ_gain_i * err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= '0;
      sum_q      <= '0;
      integ_q    <= '0;
      for (int i = 0; i < int'(AvgDepth); i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      if (adv_i.take) begin
        last_pos_q     <= pos_i;
        sum_q          <= sum_d;
        ring_q[slot_i] <= diff;
      end
      if (adv_i.s2) begin
        integ_q <= integ_d;
      end
    end
  end

  // integrator add and clamp, applied as the item leaves stage 1
  assign i_inc   = $signed(s1_iprod_q[IPW-1:24]);
  assign int_sum = (DRIVE_W+2)'(integ_q) + (DRIVE_W+2)'(i_inc);
  assign int_lim = $signed((DRIVE_W+2)'(int_limit_i));

  always_comb begin
    if (int_sum > int_lim) begin
      integ_d = DRIVE_W'(int_lim);
    end else if (int_sum < -int_lim) begin
      integ_d = DRIVE_W'(-int_lim);
    end else begin
      integ_d = DRIVE_W'(int_sum);
    end
  end

  assign dprod = s1_sum_q * deriv_gain_i;

  // floor((sum*kd >> 16) / AvgDepth) on magnitude: negatives get AvgDepth-1 added
  assign x2     = $signed(s2_dprod_q[DPW-1:16]);
  assign x2_ext = (DW+1)'(x2);
  assign u_d    = x2[DW-1] ? DW'(-x2_ext + (DW+1)'(AvgDepth - 1)) : DW'(x2_ext);
  assign mprod  = s3_u_q * RecipM;

  always_ff @(posedge clk_i) begin
    if (adv_i.take) begin
      s1_pprod_q <= pprod;
      s1_iprod_q <= iprod;
      s1_sum_q   <= sum_d;
    end
    if (adv_i.s2) begin
      s2_p_q     <= $signed(s1_pprod_q[PPW-1:16]);
      s2_integ_q <= integ_d;
      s2_dprod_q <= dprod;
    end
    if (adv_i.s3) begin
      s3_p_q     <= s2_p_q;
      s3_integ_q <= s2_integ_q;
      s3_u_q     <= u_d;
      s3_neg_q   <= x2[DW-1];
    end
    if (adv_i.s4) begin
      s4_p_q     <= s3_p_q;
      s4_integ_q <= s3_integ_q;
      s4_q_q     <= DW'(mprod >> Shift);
      s4_neg_q   <= s3_neg_q;
    end
  end

  assign dq    = $signed({1'b0, s4_q_q});
  assign d_val = s4_neg_q ? -dq : dq;
  assign total = TW'(s4_p_q) + TW'(s4_integ_q) + TW'(d_val);
  assign olim  = $signed(TW'(out_limit_i));

  always_comb begin
    if (total > olim) begin
      clamped = olim;
    end else if (total < -olim) begin
      clamped = -olim;
    end else begin
      clamped = total;
    end
  end

  assign drive_o = DRIVE_W'(clamped);

endmodule

[rtl/two_axis_pid_with_filtered_derivative_core.sv]
// Channel   Dir  Payload                              Transfer
// in_i      in   pos_x, pos_y, target_x, target_y     valid & ready
// out_o     out  drive_x, drive_y                     valid & ready
// cfg       in   cfg_idx_i, cfg_data_i                cfg_we_i
//
// One item per cycle sustained while out_o is ready; an input transfer reaches
// out_o.valid through stage 1 (loaded on the transfer edge), three more lane
// stages and the output register.
// The loop-carried state (history ring, integrator) is read and written back on
// the same stage advance, which is what allows back-to-back items.
// Stages advance independently, so bubbles collapse under an out_o stall.
// Reset clears the pipeline, the history and loads the register defaults.
module two_axis_pid_with_filtered_derivative_core #(
  parameter int unsigned AvgDepth = pid2_pkg::AVG_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pid2_in_if.sink                             in_i,
  pid2_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [pid2_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pid2_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pid2_pkg::*;

  localparam int unsigned SlotW = (AvgDepth > 1) ? $clog2(AvgDepth) : 1;

  logic signed [PGAIN_W-1:0] prop_gain_q;
  logic signed [IGAIN_W-1:0] integ_gain_q;
  logic signed [DGAIN_W-1:0] deriv_gain_q;
  logic [LIMIT_W-1:0]        int_limit_q;
  logic [LIMIT_W-1:0]        out_limit_q;

  logic [SlotW-1:0] slot_q, slot_d;
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic free1, free2, free3, free4, out_en, load_out;
  pid2_adv_t adv;

  logic signed [DRIVE_W-1:0] lane_x, lane_y;
  logic signed [DRIVE_W-1:0] drive_x_q, drive_y_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PROP_GAIN_RST;
      integ_gain_q <= INTEG_GAIN_RST;
      deriv_gain_q <= DERIV_GAIN_RST;
      int_limit_q  <= INT_LIMIT_RST;
      out_limit_q  <= OUT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (pid2_cfg_reg_e'(cfg_idx_i))
        CFG_PROP_GAIN:          prop_gain_q  <= cfg_data_i[PGAIN_W-1:0];
        CFG_INTEG_GAIN_DT:      integ_gain_q <= cfg_data_i[IGAIN_W-1:0];
        CFG_DERIV_GAIN_OVER_DT: deriv_gain_q <= cfg_data_i[DGAIN_W-1:0];
        CFG_INT_LIMIT:          int_limit_q  <= cfg_data_i[LIMIT_W-1:0];
        CFG_OUT_LIMIT:          out_limit_q  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage can take a new item if empty or emptying this cycle
  assign out_en   = !out_v_q || out_o.ready;
  assign free4    = !v4_q || out_en;
  assign free3    = !v3_q || free4;
  assign free2    = !v2_q || free3;
  assign free1    = !v1_q || free2;
  assign load_out = v4_q && out_en;

  assign in_i.ready = free1;
  assign adv.take   = in_i.valid && free1;
  assign adv.s2     = v1_q && free2;
  assign adv.s3     = v2_q && free3;
  assign adv.s4     = v3_q && free4;

  assign slot_d = (slot_q == SlotW'(AvgDepth - 1)) ? '0 : slot_q + SlotW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv.take) begin
        slot_q <= slot_d;
      end
      v1_q    <= adv.take || (v1_q && !free2);
      v2_q    <= adv.s2   || (v2_q && !free3);
      v3_q    <= adv.s3   || (v3_q && !free4);
      v4_q    <= adv.s4   || (v4_q && !out_en);
      out_v_q <= load_out || (out_v_q && !out_o.ready);
    end
  end

  pid2_lane #(.AvgDepth(AvgDepth), .SlotW(SlotW)) u_lane_x (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .pos_i        (in_i.pos_x),
    .target_i     (in_i.target_x),
    .slot_i       (slot_q),
    .prop_gain_i  (prop_gain_q),
    .integ_gain_i (integ_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .int_limit_i  (int_limit_q),
    .out_limit_i  (out_limit_q),
    .drive_o      (lane_x)
  );

  pid2_lane #(.AvgDepth(AvgDepth), .SlotW(SlotW)) u_lane_y (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .pos_i        (in_i.pos_y),
    .target_i     (in_i.target_y),
    .slot_i       (slot_q),
    .prop_gain_i  (prop_gain_q),
    .integ_gain_i (integ_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .int_limit_i  (int_limit_q),
    .out_limit_i  (out_limit_q),
    .drive_o      (lane_y)
  );

  // merge both lanes into one result
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      drive_x_q <= lane_x;
      drive_y_q <= lane_y;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.drive_x = drive_x_q;
  assign out_o.drive_y = drive_y_q;

`ifndef ASSERT_OFF
  a_take_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv.take |=> v1_q)
    else $error("accepted item did not reach stage 1");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SlotW'(AvgDepth - 1))
    else $error("history slot out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load_out && out_v_q && !out_o.ready))
    else $error("output register overwritten while stalled");

  a_s4_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_en) |=> v4_q)
    else $error("stage 4 item lost during stall");
`endif

endmodule
